FILE: sv/fcld_pkg.sv
// Shared types and constants for the frequency-count list decoder.
package fcld_pkg;

    localparam int ALPHABET   = 256;
    localparam int COUNT_BITS = 16;
    localparam int SYM_BITS   = 8;
    localparam int IDX_BITS   = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;

    localparam logic [SYM_BITS-1:0]   LAST_POS  = SYM_BITS'(ALPHABET - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef logic [SYM_BITS-1:0]   sym_t;
    typedef logic [COUNT_BITS-1:0] count_t;

    // contents of one list cell
    typedef struct packed {
        sym_t   sym;
        count_t cnt;
    } fcld_entry_t;

    // control and data broadcast to every cell
    typedef struct packed {
        logic   restore;
        logic   update;
        sym_t   pos;
        sym_t   sym;
        count_t cnt;
    } fcld_bcast_t;

endpackage

FILE: sv/fcld_cell.sv
// One list cell: holds a symbol and its count, shifts from its front neighbor.
module fcld_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  fcld_pkg::sym_t       my_index,
    input  fcld_pkg::fcld_bcast_t bcast,
    input  logic                 prev_in_region,
    input  fcld_pkg::fcld_entry_t prev_entry,
    output logic                 in_region,
    output fcld_pkg::fcld_entry_t entry
);
    import fcld_pkg::*;

    fcld_entry_t entry_reg;
    fcld_entry_t entry_next;

    // cell lies in the span that moves back by one (or takes the new entry)
    assign in_region = (my_index <= bcast.pos) && (entry_reg.cnt < bcast.cnt);
    assign entry     = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (bcast.restore) begin
            entry_next.sym = my_index;
            entry_next.cnt = '0;
        end else if (bcast.update && in_region) begin
            if (prev_in_region) begin
                entry_next = prev_entry;
            end else begin
                entry_next.sym = bcast.sym;
                entry_next.cnt = bcast.cnt;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg.sym <= my_index;
            entry_reg.cnt <= '0;
        end else begin
            entry_reg <= entry_next;
        end
    end

endmodule

FILE: sv/frequency_count_list_decoder.sv
// Top level of the frequency-count list decoder: control and the row of list cells.
//
//  channel | ports                                  | direction
//  --------+----------------------------------------+----------
//  input   | s_valid s_ready s_position s_first_of_block | in
//  result  | m_valid m_ready m_symbol               | out
//
// Each transfer passes through accept (ST_IDLE), read of the addressed cell
// and count increment (ST_READ), then update (ST_UPDATE), in which every cell
// compares its count in parallel and the moving span shifts back by one cell.
// Reset (synchronous, active low) loads identity order and zero counts.
// A stalled result holds the read cycle until the output register is free.
module frequency_count_list_decoder (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_position,
    input  logic                 s_first_of_block,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_symbol
);
    import fcld_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_READ   = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;

    logic [1:0]  state_reg, state_next;
    sym_t        pos_reg, pos_next;
    logic        first_reg, first_next;
    sym_t        bsym_reg, bsym_next;
    count_t      bcnt_reg, bcnt_next;
    logic        m_valid_reg, m_valid_next;
    sym_t        m_symbol_reg, m_symbol_next;

    fcld_bcast_t bcast;
    fcld_entry_t cell_entry [ALPHABET];
    logic        cell_in    [ALPHABET];

    fcld_entry_t rd_entry;
    sym_t        rd_sym;
    count_t      rd_cnt;
    logic        load_out;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_symbol = m_symbol_reg;

    assign rd_entry = cell_entry[pos_reg[IDX_BITS-1:0]];
    assign rd_sym   = first_reg ? pos_reg : rd_entry.sym;
    assign rd_cnt   = first_reg ? count_t'(0) : rd_entry.cnt;
    assign load_out = (state_reg == ST_READ) && (!m_valid_reg || m_ready);

    always_comb begin
        bcast.restore = load_out && first_reg;
        bcast.update  = (state_reg == ST_UPDATE);
        bcast.pos     = pos_reg;
        bcast.sym     = bsym_reg;
        bcast.cnt     = bcnt_reg;
    end

    always_comb begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        first_next    = first_reg;
        bsym_next     = bsym_reg;
        bcnt_next     = bcnt_reg;
        m_symbol_next = m_symbol_reg;
        m_valid_next  = (m_valid_reg && m_ready) ? 1'b0 : m_valid_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    pos_next   = (s_position > LAST_POS) ? LAST_POS : s_position;
                    first_next = s_first_of_block;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                if (load_out) begin
                    bsym_next     = rd_sym;
                    bcnt_next     = (rd_cnt == COUNT_MAX) ? rd_cnt : rd_cnt + count_t'(1);
                    m_symbol_next = rd_sym;
                    m_valid_next  = 1'b1;
                    state_next    = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg      <= pos_next;
        first_reg    <= first_next;
        bsym_reg     <= bsym_next;
        bcnt_reg     <= bcnt_next;
        m_symbol_reg <= m_symbol_next;
    end

    for (genvar k = 0; k < ALPHABET; k++) begin : g_cell
        logic        prev_in;
        fcld_entry_t prev_entry;
        if (k == 0) begin : g_front
            assign prev_in    = 1'b0;
            assign prev_entry = '0;
        end else begin : g_rest
            assign prev_in    = cell_in[k-1];
            assign prev_entry = cell_entry[k-1];
        end
        fcld_cell u_cell (
            .aclk           (aclk),
            .aresetn        (aresetn),
            .my_index       (sym_t'(k)),
            .bcast          (bcast),
            .prev_in_region (prev_in),
            .prev_entry     (prev_entry),
            .in_region      (cell_in[k]),
            .entry          (cell_entry[k])
        );
    end

endmodule
